[hdl/iga_pkg.sv]
package iga_pkg;

   localparam int GYRO_DEPTH    = 16;
   localparam int ACCEL_DEPTH   = 8;
   localparam int SAMPLE_BITS   = 24;
   localparam int TIME_BITS     = 48;
   localparam int FRACTION_BITS = 16;
   localparam int OFFSET_BITS   = 32;
   localparam int RESULT_LIMIT  = 16;

   localparam int GYRO_AW   = $clog2(GYRO_DEPTH);
   localparam int GYRO_CW   = $clog2(GYRO_DEPTH + 1);
   localparam int ACCEL_AW  = $clog2(ACCEL_DEPTH);
   localparam int ACCEL_CW  = $clog2(ACCEL_DEPTH + 1);
   localparam int RES_CW    = $clog2(RESULT_LIMIT + 1);
   localparam int QUOT_BITS = FRACTION_BITS + 1;

   localparam logic KIND_GYRO  = 1'b0;
   localparam logic KIND_ACCEL = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] axis_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] stamp;
      axis_type             x;
      axis_type             y;
      axis_type             z;
   } sample_type;

   localparam int SAMPLE_W = $bits(sample_type);

   typedef struct packed {
      logic                 kind;
      logic [TIME_BITS-1:0] stamp_us;
      axis_type             axis_x;
      axis_type             axis_y;
      axis_type             axis_z;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] sample_time_us;
      axis_type             gyro_x;
      axis_type             gyro_y;
      axis_type             gyro_z;
      axis_type             accel_x;
      axis_type             accel_y;
      axis_type             accel_z;
      logic                 last;
   } rsp_type;

   typedef enum logic [0:0] {
      CSR_USE_DEVICE_TIME = 1'b0,
      CSR_TIME_OFFSET     = 1'b1
   } csr_index_type;

endpackage

[hdl/iga_ram.sv]
module iga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/iga_frac.sv]
module iga_frac
   import iga_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] num,
   input  logic [TIME_BITS-1:0] den,
   output logic                 done,
   output logic [QUOT_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] den_ff, den_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [TIME_BITS:0]   shifted;
   logic                 ge;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      shifted = {rem_ff, 1'b0};
      ge      = (num >= den);
      if (start) begin
         busy_in = 1'b1;
         den_in  = den;
         cnt_in  = CNT_BITS'(FRACTION_BITS);
         quot_in = {{(QUOT_BITS-1){1'b0}}, ge};
         rem_in  = ge ? (num - den) : num;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = TIME_BITS'(shifted - {1'b0, den_ff});
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[TIME_BITS-1:0];
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hdl/iga_mac.sv]
module iga_mac
   import iga_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [QUOT_BITS-1:0] ratio,
   input  sample_type           a0,
   input  sample_type           a1,
   output logic                 done,
   output axis_type             blend_x,
   output axis_type             blend_y,
   output axis_type             blend_z
);

   localparam int PROD_BITS = QUOT_BITS + 1 + SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + 1;
   localparam logic [2:0] LAST_STEP = 3'd6;
   localparam logic [QUOT_BITS-1:0] ONE = QUOT_BITS'(1) << FRACTION_BITS;

   logic                        busy_ff, done_ff;
   logic [2:0]                  step_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   axis_type                    bx_ff, by_ff, bz_ff;
   logic [QUOT_BITS-1:0]        weight;
   axis_type                    value;
   logic signed [ACC_BITS-1:0]  sum;

   // pick weight and axis for this step: even steps old sample, odd steps new
   always_comb begin
      weight = step_ff[0] ? ratio : (ONE - ratio);
      case (step_ff[2:1])
         2'd0:    value = step_ff[0] ? a1.x : a0.x;
         2'd1:    value = step_ff[0] ? a1.y : a0.y;
         default: value = step_ff[0] ? a1.z : a0.z;
      endcase
      sum = acc_ff + ACC_BITS'(prod_ff);
   end

   // multiply into a product register, then add it to the accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff != LAST_STEP) begin
            prod_ff <= $signed({1'b0, weight}) * value;
         end
         if (step_ff != 3'd0) begin
            if (!step_ff[0]) begin
               acc_ff <= '0;
               case (step_ff[2:1])
                  2'd1:    bx_ff <= sum[FRACTION_BITS +: SAMPLE_BITS];
                  2'd2:    by_ff <= sum[FRACTION_BITS +: SAMPLE_BITS];
                  default: bz_ff <= sum[FRACTION_BITS +: SAMPLE_BITS];
               endcase
            end else begin
               acc_ff <= sum;
            end
         end
      end
   end

   assign done    = done_ff;
   assign blend_x = bx_ff;
   assign blend_y = by_ff;
   assign blend_z = bz_ff;

endmodule

[hdl/imu_gyro_accel_interpolating_aligner.sv]
// Gyro/accel aligner. Requests carry one gyro or accel sample; gyro
// requests only fill the gyro FIFO. An accel request is stored unless stale
// and then starts a walk over both FIFOs that emits up to 16 aligned results,
// each a gyro sample with the accel axes interpolated at its time. The walk
// runs under a sequencer: each step passes the check, load, capture and
// compare states, checking counts, reading the FIFO memories and comparing
// stamps; each result then adds a serial fraction divide, a shared
// multiply-accumulate over the six weighted terms and an emit step that
// waits while the receiver stalls. req_stall stays high during the walk;
// results leave through an output register and a one-deep hold stage so that
// the final result can be flagged with last.
module imu_gyro_accel_interpolating_aligner
   import iga_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [OFFSET_BITS-1:0] csr_data
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_CHECK   = 9'b000000010,
      ST_LOAD_A1 = 9'b000000100,
      ST_CAPTURE = 9'b000001000,
      ST_COMPARE = 9'b000010000,
      ST_DIVIDE  = 9'b000100000,
      ST_BLEND   = 9'b001000000,
      ST_EMIT    = 9'b010000000,
      ST_FLUSH   = 9'b100000000
   } state_type;

   state_type                state_ff, state_in;
   logic                     use_dev_ff;
   logic [OFFSET_BITS-1:0]   offset_ff;
   logic [GYRO_AW-1:0]       g_head_ff, g_head_in, g_tail_ff, g_tail_in;
   logic [GYRO_CW-1:0]       g_count_ff, g_count_in;
   logic [TIME_BITS-1:0]     g_last_ff, g_last_in;
   logic [ACCEL_AW-1:0]      a_head_ff, a_head_in, a_tail_ff, a_tail_in;
   logic [ACCEL_CW-1:0]      a_count_ff, a_count_in;
   logic [TIME_BITS-1:0]     a_last_ff, a_last_in;
   logic [RES_CW-1:0]        n_ff, n_in;
   sample_type               g_ff, g_in, a0_ff, a0_in, a1_ff, a1_in;
   rsp_type                  pend_ff, pend_in, out_ff, out_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic                     out_valid_ff, out_valid_in;

   logic                     g_wr, a_wr;
   logic [ACCEL_AW-1:0]      a_rd_addr, a_head_next;
   logic [GYRO_AW-1:0]       g_head_next;
   sample_type               in_sample, g_rd, a_rd;
   logic                     frac_start, frac_done, mac_start, mac_done;
   logic [QUOT_BITS-1:0]     ratio;
   axis_type                 bx, by, bz;
   rsp_type                  result;
   logic                     out_free, accept;

   function automatic logic [GYRO_AW-1:0] g_next(input logic [GYRO_AW-1:0] p);
      return (p == GYRO_AW'(GYRO_DEPTH - 1)) ? '0 : GYRO_AW'(p + 1'b1);
   endfunction

   function automatic logic [ACCEL_AW-1:0] a_next(input logic [ACCEL_AW-1:0] p);
      return (p == ACCEL_AW'(ACCEL_DEPTH - 1)) ? '0 : ACCEL_AW'(p + 1'b1);
   endfunction

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign g_head_next = g_next(g_head_ff);
   assign a_head_next = a_next(a_head_ff);
   assign a_rd_addr   = (state_ff == ST_LOAD_A1) ? a_head_next : a_head_ff;
   assign in_sample   = '{stamp: req_data.stamp_us, x: req_data.axis_x,
                          y: req_data.axis_y, z: req_data.axis_z};
   assign frac_start  = (state_ff == ST_COMPARE) && (g_ff.stamp >= a0_ff.stamp)
                        && (g_ff.stamp <= a1_ff.stamp);
   assign mac_start   = (state_ff == ST_DIVIDE) && frac_done;

   iga_ram #(.WIDTH(SAMPLE_W), .DEPTH(GYRO_DEPTH)) u_gyro_ram (
      .clock   (clock),
      .wr_en   (g_wr),
      .wr_addr (g_tail_ff),
      .wr_data (in_sample),
      .rd_addr (g_head_ff),
      .rd_data (g_rd)
   );

   iga_ram #(.WIDTH(SAMPLE_W), .DEPTH(ACCEL_DEPTH)) u_accel_ram (
      .clock   (clock),
      .wr_en   (a_wr),
      .wr_addr (a_tail_ff),
      .wr_data (in_sample),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd)
   );

   iga_frac u_frac (
      .clock (clock),
      .reset (reset),
      .start (frac_start),
      .num   (g_ff.stamp - a0_ff.stamp),
      .den   (a1_ff.stamp - a0_ff.stamp),
      .done  (frac_done),
      .quot  (ratio)
   );

   iga_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .ratio   (ratio),
      .a0      (a0_ff),
      .a1      (a1_ff),
      .done    (mac_done),
      .blend_x (bx),
      .blend_y (by),
      .blend_z (bz)
   );

   // assemble the aligned result
   always_comb begin
      result.sample_time_us = use_dev_ff
         ? TIME_BITS'(g_ff.stamp + TIME_BITS'($signed(offset_ff)))
         : g_ff.stamp;
      result.gyro_x  = g_ff.x;
      result.gyro_y  = g_ff.y;
      result.gyro_z  = g_ff.z;
      result.accel_x = bx;
      result.accel_y = by;
      result.accel_z = bz;
      result.last    = 1'b0;
   end

   // sequencer: push, walk, emit, flush
   always_comb begin
      state_in      = state_ff;
      g_head_in     = g_head_ff;
      g_tail_in     = g_tail_ff;
      g_count_in    = g_count_ff;
      g_last_in     = g_last_ff;
      a_head_in     = a_head_ff;
      a_tail_in     = a_tail_ff;
      a_count_in    = a_count_ff;
      a_last_in     = a_last_ff;
      n_in          = n_ff;
      g_in          = g_ff;
      a0_in         = a0_ff;
      a1_in         = a1_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      g_wr          = 1'b0;
      a_wr          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_GYRO) begin
                  // drop stale gyro, drop oldest when full
                  if (g_count_ff == '0 || req_data.stamp_us > g_last_ff) begin
                     g_wr      = 1'b1;
                     g_last_in = req_data.stamp_us;
                     g_tail_in = g_next(g_tail_ff);
                     if (g_count_ff == GYRO_CW'(GYRO_DEPTH)) begin
                        g_head_in = g_head_next;
                     end else begin
                        g_count_in = g_count_ff + 1'b1;
                     end
                  end
               end else begin
                  if (a_count_ff == '0 || req_data.stamp_us > a_last_ff) begin
                     a_wr      = 1'b1;
                     a_last_in = req_data.stamp_us;
                     a_tail_in = a_next(a_tail_ff);
                     if (a_count_ff == ACCEL_CW'(ACCEL_DEPTH)) begin
                        a_head_in = a_head_next;
                     end else begin
                        a_count_in = a_count_ff + 1'b1;
                     end
                  end
                  n_in     = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (a_count_ff >= ACCEL_CW'(2) && g_count_ff != '0
                && n_ff != RES_CW'(RESULT_LIMIT)) begin
               state_in = ST_LOAD_A1;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_LOAD_A1: begin
            g_in     = g_rd;
            a0_in    = a_rd;
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            a1_in    = a_rd;
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (g_ff.stamp < a0_ff.stamp) begin
               g_head_in  = g_head_next;
               g_count_in = g_count_ff - 1'b1;
               state_in   = ST_CHECK;
            end else if (g_ff.stamp > a1_ff.stamp) begin
               a_head_in  = a_head_next;
               a_count_in = a_count_ff - 1'b1;
               state_in   = ST_CHECK;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (frac_done) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hand the held result on, hold the new one
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_in       = pend_ff;
                  out_valid_in = 1'b1;
               end
               pend_in       = result;
               pend_valid_in = 1'b1;
               n_in          = n_ff + 1'b1;
               g_head_in     = g_head_next;
               g_count_in    = g_count_ff - 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         use_dev_ff    <= 1'b1;
         offset_ff     <= '0;
         g_head_ff     <= '0;
         g_tail_ff     <= '0;
         g_count_ff    <= '0;
         a_head_ff     <= '0;
         a_tail_ff     <= '0;
         a_count_ff    <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         g_head_ff     <= g_head_in;
         g_tail_ff     <= g_tail_in;
         g_count_ff    <= g_count_in;
         a_head_ff     <= a_head_in;
         a_tail_ff     <= a_tail_in;
         a_count_ff    <= a_count_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_USE_DEVICE_TIME: use_dev_ff <= csr_data[0];
               CSR_TIME_OFFSET:     offset_ff  <= csr_data;
               default:             ;
            endcase
         end
      end
      g_last_ff <= g_last_in;
      a_last_ff <= a_last_in;
      g_ff      <= g_in;
      a0_ff     <= a0_in;
      a1_ff     <= a1_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_gyro_count: assert property (@(posedge clock) disable iff (reset)
      g_count_ff <= GYRO_CW'(GYRO_DEPTH))
      else $error("gyro count above depth");
   a_accel_count: assert property (@(posedge clock) disable iff (reset)
      a_count_ff <= ACCEL_CW'(ACCEL_DEPTH))
      else $error("accel count above depth");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held result left behind at idle");
   a_result_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RES_CW'(RESULT_LIMIT))
      else $error("too many results for one request");
   a_emit_needs_gyro: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (g_count_ff != '0))
      else $error("emit without gyro sample");
`endif

endmodule
